// ===== design/rad_pkg.sv =====
// ----------------------------------------------------------------------------
// rad_pkg: shared types and constants for the resource allocator
// Sizes, field widths, command and status codes, controller state and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package rad_pkg;

    localparam int PROCS   = 18;
    localparam int RES     = 20;
    localparam int PROC_W  = $clog2(PROCS);
    localparam int RES_W   = $clog2(RES);
    localparam int CNT_W   = 4;
    localparam int ROW_W   = RES * CNT_W;
    localparam int WORK_W  = $clog2(15 * (PROCS + 1) + 1);
    localparam int LIM_W   = 8;

    localparam int FUNC_W  = 2;
    localparam int PFLD_W  = 5;
    localparam int RFLD_W  = 5;
    localparam int STAT_W  = 3;
    localparam int MASK_W  = 20;
    localparam int ACT_W   = 5;
    localparam int CIDX_W  = 2;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 16;

    localparam logic [CNT_W-1:0] CNT_MAX    = 4'd15;
    localparam logic [CNT_W-1:0] INIT_RST   = 4'd10;
    localparam logic [CNT_W-1:0] LIMIT_RST  = 4'd7;
    localparam logic [ACT_W-1:0] ACTIVE_RST = 5'd18;

    typedef enum logic [FUNC_W-1:0] {
        FN_REQ  = 2'd0,
        FN_REL  = 2'd1,
        FN_TERM = 2'd2,
        FN_DET  = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_GRANT  = 3'd0,
        ST_DENY   = 3'd1,
        ST_RDONE  = 3'd2,
        ST_RIGN   = 3'd3,
        ST_TERM   = 3'd4,
        ST_NONE   = 3'd5,
        ST_VICTIM = 3'd6
    } status_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_SHARED = 2'd0,
        CFG_INIT   = 2'd1,
        CFG_LIMIT  = 2'd2,
        CFG_ACTIVE = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ITEM_RD,
        S_ITEM_EX,
        S_DET_START,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_VIC_SEL,
        S_VIC_FREE,
        S_DONE
    } state_t;

    typedef logic [RES-1:0][CNT_W-1:0] cnt_row_t;

    typedef struct packed {
        logic in_ready;
        logic rd_item;
        logic exec_item;
        logic det_start;
        logic rd_scan;
        logic chk_scan;
        logic sel_vic;
        logic free_vic;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  lim_zero;
        logic  scan_last;
        logic  progress;
        logic  vic_found;
        logic  out_room;
    } sts_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

// ===== design/rad_ram.sv =====
// ----------------------------------------------------------------------------
// rad_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/rad_ctl.sv =====
// ----------------------------------------------------------------------------
// rad_ctl: allocator controller
// Sequences item handling, the detection scan and victim release.
// ----------------------------------------------------------------------------
module rad_ctl
    import rad_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_ITEM_RD;
                end
            end
            S_ITEM_RD:
            begin
                state_next = (sts.func == FN_DET) ? S_DET_START : S_ITEM_EX;
            end
            S_ITEM_EX:
            begin
                state_next = S_DONE;
            end
            S_DET_START:
            begin
                state_next = sts.lim_zero ? S_VIC_SEL : S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (sts.scan_last && !sts.progress)
                begin
                    state_next = S_VIC_SEL;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_VIC_SEL:
            begin
                state_next = sts.vic_found ? S_VIC_FREE : S_DONE;
            end
            S_VIC_FREE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_room)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:      cmd.in_ready  = 1'b1;
            S_ITEM_RD:   cmd.rd_item   = 1'b1;
            S_ITEM_EX:   cmd.exec_item = 1'b1;
            S_DET_START: cmd.det_start = 1'b1;
            S_SCAN_RD:   cmd.rd_scan   = 1'b1;
            S_SCAN_CHK:  cmd.chk_scan  = 1'b1;
            S_VIC_SEL:   cmd.sel_vic   = 1'b1;
            S_VIC_FREE:  cmd.free_vic  = 1'b1;
            S_DONE:      cmd.load_out  = sts.out_room;
            default:     cmd = '0;
        endcase
    end

endmodule

// ===== design/rad_dp.sv =====
// ----------------------------------------------------------------------------
// rad_dp: allocator datapath
// Count matrices in RAM (one row per process), free counts, detection
// work vector, configuration registers and the output register.
// ----------------------------------------------------------------------------
module rad_dp
    import rad_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic              s_tvalid,
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [MASK_W-1:0] cfg_data
);

    // configuration
    logic [MASK_W-1:0] shared_reg;
    logic [CNT_W-1:0]  limit_reg;
    logic [ACT_W-1:0]  active_reg;

    // captured item
    func_t             func_reg;
    logic [PFLD_W-1:0] proc_reg;
    logic [RFLD_W-1:0] res_reg;

    // state
    cnt_row_t                       free_reg;
    cnt_row_t                       free_next;
    logic [PROCS-1:0]               vld_reg;
    logic [PROCS-1:0]               vld_next;
    logic [RES-1:0][WORK_W-1:0]     work_reg;
    logic [PROCS-1:0]               done_reg;
    logic [PROC_W-1:0]              scan_reg;
    logic                           prog_reg;
    logic [PROC_W-1:0]              vic_reg;
    logic                           rd_vld_reg;

    // result and output
    status_t           res_status_reg;
    status_t           res_status_next;
    logic [PFLD_W-1:0] res_subject_reg;
    logic [PFLD_W-1:0] res_subject_next;
    logic [RFLD_W-1:0] res_echo_reg;
    logic [RFLD_W-1:0] res_echo_next;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    // RAM
    logic                 ram_we;
    logic [PROC_W-1:0]    ram_waddr;
    logic [2*ROW_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [PROC_W-1:0]    ram_raddr;
    logic [2*ROW_W-1:0]   ram_rdata;

    cnt_row_t          held_row;
    cnt_row_t          pend_row;
    cnt_row_t          held_new;
    cnt_row_t          pend_new;
    logic [RES-1:0]    sh_vec;
    logic [LIM_W-1:0]  lim;
    logic [PROC_W-1:0] p_idx;
    logic [RES_W-1:0]  r_idx;
    logic              p_ok;
    logic              ok;
    logic              can_fin;
    logic              pass_now;
    logic              scan_last;
    logic              vic_found;
    logic [PROC_W-1:0] vic_idx;
    logic [CNT_W-1:0]  h;
    logic [CNT_W-1:0]  pd;
    logic [CNT_W-1:0]  fr;
    logic              sh;
    logic              grant;

    rad_ram #(
        .WIDTH (2 * ROW_W),
        .DEPTH (PROCS)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sh_vec = RES'(shared_reg);
    assign lim    = (LIM_W'(active_reg) < LIM_W'(PROCS)) ? LIM_W'(active_reg) : LIM_W'(PROCS);
    assign p_idx  = PROC_W'(proc_reg);
    assign r_idx  = RES_W'(res_reg);
    assign p_ok   = LIM_W'(proc_reg) < lim;
    assign ok     = p_ok && (LIM_W'(res_reg) < LIM_W'(RES));

    // rows never written since reset or release read as zero
    always_comb
    begin
        for (int i = 0; i < RES; i++)
        begin
            held_row[i] = rd_vld_reg ? ram_rdata[i*CNT_W +: CNT_W] : '0;
            pend_row[i] = rd_vld_reg ? ram_rdata[ROW_W + i*CNT_W +: CNT_W] : '0;
        end
    end

    always_comb
    begin
        ram_re    = cmd.rd_item || cmd.rd_scan || cmd.sel_vic;
        ram_raddr = p_idx;
        if (cmd.rd_scan)
        begin
            ram_raddr = scan_reg;
        end
        else if (cmd.sel_vic)
        begin
            ram_raddr = vic_idx;
        end
    end

    // detection test against the work vector
    always_comb
    begin
        can_fin = 1'b1;
        for (int i = 0; i < RES; i++)
        begin
            if (sh_vec[i] && (pend_row[i] != '0) && (held_row[i] >= limit_reg))
            begin
                can_fin = 1'b0;
            end
            if (WORK_W'(pend_row[i]) > work_reg[i])
            begin
                can_fin = 1'b0;
            end
        end
    end

    assign pass_now  = !done_reg[scan_reg] && can_fin;
    assign scan_last = (LIM_W'(scan_reg) + LIM_W'(1)) >= lim;

    // lowest slot left unfinished
    always_comb
    begin
        vic_found = 1'b0;
        vic_idx   = '0;
        for (int q = PROCS - 1; q >= 0; q--)
        begin
            if (!done_reg[q] && (LIM_W'(q) < lim))
            begin
                vic_found = 1'b1;
                vic_idx   = PROC_W'(q);
            end
        end
    end

    always_comb
    begin
        h  = held_row[r_idx];
        pd = pend_row[r_idx];
        fr = free_reg[r_idx];
        sh = sh_vec[r_idx];
        grant = sh ? ((h < limit_reg) && (h < CNT_MAX))
                   : ((fr != '0) && (h < CNT_MAX));
    end

    always_comb
    begin
        held_new         = held_row;
        pend_new         = pend_row;
        free_next        = free_reg;
        vld_next         = vld_reg;
        ram_we           = 1'b0;
        ram_waddr        = p_idx;
        res_status_next  = res_status_reg;
        res_subject_next = res_subject_reg;
        res_echo_next    = res_echo_reg;

        if (cmd.exec_item)
        begin
            res_subject_next = proc_reg;
            res_echo_next    = res_reg;
            unique case (func_reg)
                FN_REQ:
                begin
                    res_status_next = ST_DENY;
                    if (ok)
                    begin
                        ram_we          = 1'b1;
                        vld_next[p_idx] = 1'b1;
                        if (grant)
                        begin
                            held_new[r_idx] = h + CNT_W'(1);
                            if (!sh)
                            begin
                                free_next[r_idx] = fr - CNT_W'(1);
                            end
                            res_status_next = ST_GRANT;
                        end
                        else if (pd != CNT_MAX)
                        begin
                            pend_new[r_idx] = pd + CNT_W'(1);
                        end
                    end
                end
                FN_REL:
                begin
                    res_status_next = ST_RIGN;
                    if (ok && (h != '0))
                    begin
                        ram_we          = 1'b1;
                        vld_next[p_idx] = 1'b1;
                        held_new[r_idx] = h - CNT_W'(1);
                        if (!sh)
                        begin
                            free_next[r_idx] = sat_add(fr, CNT_W'(1));
                        end
                        res_status_next = ST_RDONE;
                    end
                end
                FN_TERM:
                begin
                    res_status_next = ST_TERM;
                    res_echo_next   = '0;
                    if (p_ok)
                    begin
                        vld_next[p_idx] = 1'b0;
                        for (int i = 0; i < RES; i++)
                        begin
                            if (!sh_vec[i])
                            begin
                                free_next[i] = sat_add(free_reg[i], held_row[i]);
                            end
                        end
                    end
                end
                FN_DET:
                begin
                    res_status_next = ST_NONE;
                end
                default:
                begin
                    res_status_next = ST_NONE;
                end
            endcase
        end

        if (cmd.sel_vic)
        begin
            res_echo_next    = '0;
            res_status_next  = vic_found ? ST_VICTIM : ST_NONE;
            res_subject_next = vic_found ? PFLD_W'(vic_idx) : '0;
        end

        if (cmd.free_vic)
        begin
            vld_next[vic_reg] = 1'b0;
            for (int i = 0; i < RES; i++)
            begin
                if (!sh_vec[i])
                begin
                    free_next[i] = sat_add(free_reg[i], held_row[i]);
                end
            end
        end

        // reload every free count with the new initial value
        if (cfg_we && (cfg_index == CFG_INIT))
        begin
            for (int i = 0; i < RES; i++)
            begin
                free_next[i] = cfg_data[CNT_W-1:0];
            end
        end
    end

    assign ram_wdata = {pend_new, held_new};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shared_reg    <= '0;
            limit_reg     <= LIMIT_RST;
            active_reg    <= ACTIVE_RST;
            free_reg      <= {RES{INIT_RST}};
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_SHARED: shared_reg <= cfg_data;
                    // free counts reload through free_next
                    CFG_INIT:   ;
                    CFG_LIMIT:  limit_reg  <= cfg_data[CNT_W-1:0];
                    CFG_ACTIVE: active_reg <= cfg_data[ACT_W-1:0];
                    default:    shared_reg <= shared_reg;
                endcase
            end
            free_reg <= free_next;
            vld_reg  <= vld_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_ready && s_tvalid)
        begin
            func_reg <= func_t'(s_tdata[FUNC_W-1:0]);
            proc_reg <= s_tdata[FUNC_W +: PFLD_W];
            res_reg  <= s_tdata[FUNC_W + PFLD_W +: RFLD_W];
        end
        if (ram_re)
        begin
            rd_vld_reg <= (LIM_W'(ram_raddr) < LIM_W'(PROCS)) ? vld_reg[ram_raddr] : 1'b0;
        end
        if (cmd.det_start)
        begin
            for (int i = 0; i < RES; i++)
            begin
                work_reg[i] <= WORK_W'(free_reg[i]);
            end
            done_reg <= '0;
            scan_reg <= '0;
            prog_reg <= 1'b0;
        end
        if (cmd.chk_scan)
        begin
            if (pass_now)
            begin
                done_reg[scan_reg] <= 1'b1;
                for (int i = 0; i < RES; i++)
                begin
                    work_reg[i] <= work_reg[i] + WORK_W'(held_row[i]);
                end
            end
            // wrap the scan and start a fresh pass
            if (scan_last)
            begin
                scan_reg <= '0;
                prog_reg <= 1'b0;
            end
            else
            begin
                scan_reg <= scan_reg + PROC_W'(1);
                prog_reg <= prog_reg || pass_now;
            end
        end
        if (cmd.sel_vic)
        begin
            vic_reg <= vic_idx;
        end
        res_status_reg  <= res_status_next;
        res_subject_reg <= res_subject_next;
        res_echo_reg    <= res_echo_next;
        if (cmd.load_out)
        begin
            out_data_reg <= OUT_W'({res_echo_reg, res_subject_reg, res_status_reg});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        sts.func      = func_reg;
        sts.lim_zero  = (lim == '0);
        sts.scan_last = scan_last;
        sts.progress  = prog_reg || pass_now;
        sts.vic_found = vic_found;
        sts.out_room  = !out_valid_reg || m_tready;
    end

endmodule

// ===== design/resource_allocator_deadlock_detect_core.sv =====
// ----------------------------------------------------------------------------
// resource_allocator_deadlock_detect_core: resource allocator with deadlock
// detection
// Grants, releases, terminations and deadlock detection on per-process
// held and pending count matrices.
// ----------------------------------------------------------------------------
// One item at a time. Request, release and terminate go through accept,
// row read, update and result load, set by the read-modify-write of one
// process row in the count RAM. A detect item scans process rows with a
// row read and a row check per row; each pass covers the active slots and
// passes repeat while a slot finishes. No clearing pass after reset:
// per-row valid bits make unwritten rows read as zero. The result sits in an
// output register, so the result of one item may wait while the next item
// is accepted.
module resource_allocator_deadlock_detect_core
    import rad_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // func[1:0], process[6:2], resource[11:7]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // status[2:0], subject[7:3], resource_echo[12:8]
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [MASK_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    rad_ctl u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    rad_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    assign s_tready = cmd.in_ready;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    a_none_subject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[2:0] == ST_NONE)) |-> (m_tdata[7:3] == '0))
        else $error("no-deadlock result carries a nonzero subject");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] != 3'b111))
        else $error("result status out of range");

    a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result loaded over a waiting result");

endmodule
